FILE: rtl/core/iidl_pkg.sv
// Shared constants, codes and types of the indexed insert/delete list.
// No dependencies; every other file of the block refers to it by scoped name.
package iidl_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FIELD_W    = 7;
  localparam int VALUE_W    = 32;
  localparam int CMP_W      = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int WIDE_W     = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int GROUP_SZ   = 8;
  localparam int NGROUP     = (DEPTH + GROUP_SZ - 1) / GROUP_SZ;

  localparam logic [FIELD_W-1:0] CAP_RESET = 7'd8;

  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_DELETE    = 3'd2,
    MODE_READ      = 3'd3,
    MODE_OVERWRITE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic [DATA_WIDTH-1:0]   data;
    logic [IDX_W-1:0]        rd_idx;
  } cell_cmd_t;

  // Zero maps to one, anything beyond the store maps to its depth
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [FIELD_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (CMP_W'(v) > CMP_W'(DEPTH)) begin
      res = CNT_W'(DEPTH);
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/iidl_if.sv
// Valid/ready channel interfaces for the list's operation and result streams.
// Depends on iidl_pkg for field widths.
interface iidl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           mode;
  logic [iidl_pkg::FIELD_W-1:0]         position;
  logic signed [iidl_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface iidl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iidl_pkg::VALUE_W-1:0]  read_value;
  logic [1:0]                           status;
  logic [iidl_pkg::FIELD_W-1:0]         count;
  logic [iidl_pkg::FIELD_W-1:0]         capacity;
  logic                                 empty_res;
  logic                                 full_res;

  modport source (output valid, output read_value, output status, output count,
                  output capacity, output empty_res, output full_res, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input capacity, input empty_res, input full_res, output ready);
endinterface

FILE: rtl/core/iidl_cell.sv
// One storage cell of the list chain: holds a single entry and trades it with
// its neighbors on insert and delete. Depends on iidl_pkg.
module iidl_cell (
  input  logic                               clk,
  input  logic [iidl_pkg::IDX_W-1:0]         cell_idx,
  input  iidl_pkg::cell_cmd_t                cmd,
  input  logic [iidl_pkg::DATA_WIDTH-1:0]    left_q,
  input  logic [iidl_pkg::DATA_WIDTH-1:0]    right_q,
  output logic [iidl_pkg::DATA_WIDTH-1:0]    q,
  output logic [iidl_pkg::DATA_WIDTH-1:0]    rd_q
);

  logic [iidl_pkg::DATA_WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      iidl_pkg::CELL_INSERT: begin
        // cells past the slot take their left neighbor, the slot takes the data
        if (cell_idx > cmd.idx) begin
          q_r <= left_q;
        end else if (cell_idx == cmd.idx) begin
          q_r <= cmd.data;
        end
      end
      iidl_pkg::CELL_DELETE: begin
        if (cell_idx >= cmd.idx) begin
          q_r <= right_q;
        end
      end
      iidl_pkg::CELL_WRITE: begin
        if (cell_idx == cmd.idx) begin
          q_r <= cmd.data;
        end
      end
      default: begin
      end
    endcase
  end

  assign q    = q_r;
  // drive zero unless addressed, so the read tree is a plain OR
  assign rd_q = (cell_idx == cmd.rd_idx) ? q_r : '0;

endmodule

FILE: rtl/core/iidl_ctrl.sv
// Controller of the list: count and capacity bookkeeping, operation decode,
// cell commands and the result register. Depends on iidl_pkg and iidl_if.
module iidl_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  iidl_in_if.sink                           in_if,
  iidl_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [iidl_pkg::FIELD_W-1:0]      cfg_wdata,
  input  logic [iidl_pkg::DATA_WIDTH-1:0]   rd_word,
  output iidl_pkg::cell_cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_DELIVER
  } state_t;

  localparam int CW = iidl_pkg::CNT_W;
  localparam int MW = iidl_pkg::CMP_W;

  state_t                            state_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     cap_r, cap_nxt;
  logic [iidl_pkg::IDX_W-1:0]        rd_idx_r;
  logic                              rd_ok_r, rd_ok_nxt;
  logic                              rd_fail_r, rd_fail_nxt;
  iidl_pkg::status_t                 status_r, status_nxt;

  logic                              out_valid_r;
  logic [iidl_pkg::VALUE_W-1:0]      out_value_r;
  logic [1:0]                        out_status_r;
  logic [iidl_pkg::FIELD_W-1:0]      out_count_r;
  logic [iidl_pkg::FIELD_W-1:0]      out_cap_r;
  logic                              out_empty_r;
  logic                              out_full_r;

  logic                              accept;
  logic [MW-1:0]                     pos_c, cnt_c;
  logic                              phys_full;
  logic [CW:0]                       cap_dbl;
  logic [CW-1:0]                     cap_grown;
  logic [CW-1:0]                     cap_half;
  iidl_pkg::cell_op_t                op_c;
  logic [iidl_pkg::IDX_W-1:0]        idx_c;
  logic [iidl_pkg::VALUE_W-1:0]      value_u;
  logic [iidl_pkg::VALUE_W-1:0]      rd_ext;
  logic                              out_free;

  assign accept    = in_if.valid && in_if.ready;
  assign pos_c     = MW'(in_if.position);
  assign cnt_c     = MW'(count_r);
  assign phys_full = (count_r == CW'(iidl_pkg::DEPTH));
  assign cap_dbl   = {cap_r, 1'b0};
  assign cap_grown = (cap_dbl > (CW + 1)'(iidl_pkg::DEPTH)) ? CW'(iidl_pkg::DEPTH)
                                                             : cap_dbl[CW-1:0];
  assign cap_half  = ((cap_r >> 1) == '0) ? CW'(1) : (cap_r >> 1);
  assign value_u   = in_if.value;

  always_comb begin
    status_nxt  = iidl_pkg::ST_DONE;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    op_c        = iidl_pkg::CELL_HOLD;
    idx_c       = iidl_pkg::IDX_W'(in_if.position);
    rd_ok_nxt   = 1'b0;
    rd_fail_nxt = 1'b0;
    case (in_if.mode)
      iidl_pkg::MODE_INSERT: begin
        if (pos_c > cnt_c) begin
          status_nxt = iidl_pkg::ST_BOUNDS;
        end else if (phys_full) begin
          status_nxt = iidl_pkg::ST_FULL;
        end else begin
          if (count_r >= cap_r) begin
            cap_nxt = cap_grown;
          end
          count_nxt = count_r + CW'(1);
          op_c      = iidl_pkg::CELL_INSERT;
        end
      end
      iidl_pkg::MODE_APPEND: begin
        if (phys_full) begin
          status_nxt = iidl_pkg::ST_FULL;
        end else begin
          if (count_r >= cap_r) begin
            cap_nxt = cap_grown;
          end
          count_nxt = count_r + CW'(1);
          op_c      = iidl_pkg::CELL_WRITE;
          idx_c     = count_r[iidl_pkg::IDX_W-1:0];
        end
      end
      iidl_pkg::MODE_DELETE: begin
        if (pos_c >= cnt_c) begin
          status_nxt = iidl_pkg::ST_BOUNDS;
        end else begin
          // shrink when the last index drops to half of the capacity
          if ((count_r - CW'(1)) == ((cap_r - CW'(1)) >> 1)) begin
            cap_nxt = cap_half;
          end
          count_nxt = count_r - CW'(1);
          op_c      = iidl_pkg::CELL_DELETE;
        end
      end
      iidl_pkg::MODE_READ: begin
        if (pos_c >= cnt_c) begin
          status_nxt  = iidl_pkg::ST_BOUNDS;
          rd_fail_nxt = 1'b1;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      iidl_pkg::MODE_OVERWRITE: begin
        if (pos_c >= cnt_c) begin
          status_nxt = iidl_pkg::ST_BOUNDS;
        end else begin
          op_c = iidl_pkg::CELL_WRITE;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.op     = accept ? op_c : iidl_pkg::CELL_HOLD;
  assign cmd.idx    = idx_c;
  assign cmd.data   = iidl_pkg::DATA_WIDTH'(iidl_pkg::WIDE_W'(value_u));
  assign cmd.rd_idx = rd_idx_r;

  assign rd_ext   = iidl_pkg::VALUE_W'(iidl_pkg::WIDE_W'(rd_word));
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= iidl_pkg::clamp_cap(iidl_pkg::CAP_RESET);
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      rd_fail_r   <= 1'b0;
      status_r    <= iidl_pkg::ST_DONE;
    end else begin
      // load a finished operation, or drop a result once it transfers
      if ((state_r == S_DELIVER) && out_free) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= rd_ok_r ? rd_ext : (rd_fail_r ? '1 : '0);
        out_status_r <= status_r;
        out_count_r  <= iidl_pkg::FIELD_W'(count_r);
        out_cap_r    <= iidl_pkg::FIELD_W'(cap_r);
        out_empty_r  <= (count_r == '0);
        out_full_r   <= (count_r >= cap_r);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            count_r <= '0;
            cap_r   <= iidl_pkg::clamp_cap(cfg_wdata);
          end else if (accept) begin
            count_r   <= count_nxt;
            cap_r     <= cap_nxt;
            status_r  <= status_nxt;
            rd_ok_r   <= rd_ok_nxt;
            rd_fail_r <= rd_fail_nxt;
            rd_idx_r  <= iidl_pkg::IDX_W'(in_if.position);
            state_r   <= S_GATHER;
          end
        end
        S_GATHER: begin
          // read tree stage registers during this cycle
          state_r <= S_DELIVER;
        end
        S_DELIVER: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready       = (state_r == S_IDLE) && !cfg_we;
  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = out_value_r;
  assign out_if.status     = out_status_r;
  assign out_if.count      = out_count_r;
  assign out_if.capacity   = out_cap_r;
  assign out_if.empty_res  = out_empty_r;
  assign out_if.full_res   = out_full_r;

endmodule

FILE: rtl/core/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list: chain of entry cells, the
// registered read tree and the controller. Depends on iidl_pkg, iidl_if,
// iidl_cell and iidl_ctrl.
//
// Use: operations arrive on in_if (mode, position, value) under valid/ready;
// each accepted operation produces exactly one result on out_if (read_value,
// status, count, capacity, empty_res, full_res). Insert, append, delete and
// overwrite act on every entry at once: each cell takes its neighbor's entry,
// the new value or keeps its own in the accept cycle.
// Steps of one operation: accept, one read tree stage, result load; the block
// takes no new operation until the current one has loaded its result. The
// registered read tree of 8-entry groups adds the middle step.
// The result register parts the two sides: a new operation is accepted while
// the last result still waits. If the receiver stalls, a finished operation
// holds in its last stage until the result register frees up, and no further
// operation is accepted meanwhile.
// cfg_we writes the initial capacity (0 reads as 1, above the depth as the
// depth) and empties the list; write it only while idle.
// Reset (synchronous, rst_n low): count 0, capacity 8, no result pending.
// Entries are not cleared; only entries below the count are ever read.
module indexed_insert_delete_list (
  input  logic                           clk,
  input  logic                           rst_n,
  iidl_in_if.sink                        in_if,
  iidl_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [iidl_pkg::FIELD_W-1:0]   cfg_wdata
);

  localparam int DW = iidl_pkg::DATA_WIDTH;

  iidl_pkg::cell_cmd_t   cmd;
  logic [DW-1:0]         cell_q  [iidl_pkg::DEPTH];
  logic [DW-1:0]         cell_rd [iidl_pkg::DEPTH];
  logic [DW-1:0]         group_r [iidl_pkg::NGROUP];
  logic [DW-1:0]         group_nxt [iidl_pkg::NGROUP];
  logic [DW-1:0]         rd_word;

  for (genvar i = 0; i < iidl_pkg::DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == iidl_pkg::DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    iidl_cell u_cell (
      .clk      (clk),
      .cell_idx (iidl_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i]),
      .rd_q     (cell_rd[i])
    );
  end

  // first tree level: OR the addressed cell out of each group of eight
  always_comb begin
    for (int g = 0; g < iidl_pkg::NGROUP; g++) begin
      group_nxt[g] = '0;
      for (int k = 0; k < iidl_pkg::GROUP_SZ; k++) begin
        if (g * iidl_pkg::GROUP_SZ + k < iidl_pkg::DEPTH) begin
          group_nxt[g] = group_nxt[g] | cell_rd[g * iidl_pkg::GROUP_SZ + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < iidl_pkg::NGROUP; g++) begin
      group_r[g] <= group_nxt[g];
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < iidl_pkg::NGROUP; g++) begin
      rd_word = rd_word | group_r[g];
    end
  end

  iidl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_word   (rd_word),
    .cmd       (cmd)
  );

endmodule

FILE: rtl/core/iidl_checker.sv
// Port-level checks of the indexed insert/delete list, attached by bind.
// Depends on iidl_pkg and the top level indexed_insert_delete_list.
module iidl_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [iidl_pkg::VALUE_W-1:0]  read_value,
  input  logic [1:0]                           status,
  input  logic [iidl_pkg::FIELD_W-1:0]         count,
  input  logic [iidl_pkg::FIELD_W-1:0]         capacity,
  input  logic                                 empty_res,
  input  logic                                 full_res
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status)
      && $stable(count) && $stable(capacity))
    else $error("result changed while stalled");

  // one operation at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while an operation is in flight");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (empty_res == (count == '0)) && (full_res == (count >= capacity)))
    else $error("empty or full flag disagrees with count and capacity");

  a_store_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == iidl_pkg::ST_FULL)
      |-> (count == iidl_pkg::FIELD_W'(iidl_pkg::DEPTH)) && (read_value == '0))
    else $error("store-full status without a full store");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (capacity != '0) && (capacity <= iidl_pkg::FIELD_W'(iidl_pkg::DEPTH)))
    else $error("capacity out of range");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .read_value (out_if.read_value),
  .status     (out_if.status),
  .count      (out_if.count),
  .capacity   (out_if.capacity),
  .empty_res  (out_if.empty_res),
  .full_res   (out_if.full_res)
);
